### src/bcd_calendar_time_editor_macros.svh
// Assertion macros for the BCD calendar time editor
`ifndef BCD_CALENDAR_TIME_EDITOR_MACROS_SVH
`define BCD_CALENDAR_TIME_EDITOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BCTE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcte: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BCTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcte: next-cycle check failed");

`endif

### src/bcte_pkg.sv
// Types, codes and BCD helper functions for the calendar time editor
`default_nettype none

package bcte_pkg;

  // Key event codes
  typedef enum logic [1:0] {
    REQ_SELECT = 2'd0,
    REQ_INC    = 2'd1,
    REQ_DEC    = 2'd2,
    REQ_EXIT   = 2'd3
  } req_e;

  // Field under edit
  typedef enum logic [2:0] {
    FIELD_NONE    = 3'd0,
    FIELD_YEAR    = 3'd1,
    FIELD_MONTH   = 3'd2,
    FIELD_DAY     = 3'd3,
    FIELD_WEEKDAY = 3'd4,
    FIELD_HOUR    = 3'd5,
    FIELD_MIN     = 3'd6,
    FIELD_SEC     = 3'd7
  } field_e;

  // Seven bytes of date and time; sec lands in the low byte
  typedef struct packed {
    logic [7:0] year;
    logic [7:0] weekday;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] min;
    logic [7:0] sec;
  } time_t;

  localparam int unsigned TimeW = $bits(time_t);

  localparam logic [7:0] MonthFeb  = 8'h02;
  localparam logic [7:0] MonthJan  = 8'h01;
  localparam logic [7:0] MonthDec  = 8'h12;
  localparam logic [7:0] MonthWrap = 8'h13;
  localparam logic [7:0] MonthSep  = 8'h09;
  localparam logic [7:0] YearWrap  = 8'ha0;
  localparam logic [7:0] YearMax   = 8'h99;
  localparam logic [7:0] HourWrap  = 8'h24;
  localparam logic [7:0] HourMax   = 8'h23;
  localparam logic [7:0] SixtyWrap = 8'h60;
  localparam logic [7:0] SixtyMax  = 8'h59;
  localparam logic [7:0] WdayMax   = 8'h07;
  localparam logic [7:0] DayFirst  = 8'h01;

  // Year 2000 + 10*hi + lo; the only century years in reach are 2000 and 2100
  function automatic logic leap_year(input logic [7:0] y);
    logic [7:0] v;
    v = {1'b0, y[7:4], 3'b000} + {3'b000, y[7:4], 1'b0} + {4'h0, y[3:0]};
    return (v[1:0] == 2'b00) && (v != 8'd100);
  endfunction

  // BCD month length, zero for a month byte that is not a month
  function automatic logic [7:0] month_len(input logic [7:0] m, input logic [7:0] y);
    logic [7:0] len;
    unique case (m) inside
      8'h02: len = leap_year(y) ? 8'h29 : 8'h28;
      8'h01, 8'h03, 8'h05, 8'h07, 8'h08, 8'h10, 8'h12: len = 8'h31;
      8'h04, 8'h06, 8'h09, 8'h11: len = 8'h30;
      default: len = 8'h00;
    endcase
    return len;
  endfunction

  // BCD step up with decimal carry out of the low digit
  function automatic logic [7:0] bcd_up(input logic [7:0] v);
    logic [7:0] s;
    logic [7:0] c;
    s = v + 8'd1;
    c = s + 8'h10;
    return (s[3:0] == 4'ha) ? {c[7:4], 4'h0} : s;
  endfunction

  // BCD step down with borrow into the high digit
  function automatic logic [7:0] bcd_down(input logic [7:0] v);
    logic [7:0] b;
    b = v - 8'h10;
    return (v[3:0] == 4'h0) ? {b[7:4], 4'h9} : (v - 8'd1);
  endfunction

endpackage

`default_nettype wire

### src/bcte_edit.sv
// Combinational edit of the clock bytes for one key event
`default_nettype none

module bcte_edit (
  input  bcte_pkg::req_e   req_i,
  input  bcte_pkg::field_e field_i,
  input  bcte_pkg::time_t  time_i,
  output bcte_pkg::field_e field_o,
  output bcte_pkg::time_t  time_o
);
  import bcte_pkg::*;

  // Field position update: select walks 1..7, exit leaves editing
  always_comb begin
    unique case (req_i)
      REQ_SELECT: field_o = (field_i == FIELD_SEC) ? FIELD_YEAR : field_e'(field_i + 3'd1);
      REQ_EXIT:   field_o = FIELD_NONE;
      default:    field_o = field_i;
    endcase
  end

  // Byte update for increment and decrement
  always_comb begin
    time_t      t;
    logic [7:0] lim;
    t   = time_i;
    lim = 8'h00;
    if (req_i == REQ_INC) begin
      unique case (field_i)
        FIELD_YEAR: begin
          t.year = bcd_up(t.year);
          if (t.year == YearWrap) t.year = 8'h00;
          lim = month_len(MonthFeb, t.year);
          if (t.month == MonthFeb && t.day > lim) t.day = lim;
        end
        FIELD_MONTH: begin
          t.month = bcd_up(t.month);
          if (t.month == MonthWrap) t.month = MonthJan;
          lim = month_len(t.month, t.year);
          if (lim != 8'h00 && t.day > lim) t.day = lim;
        end
        FIELD_DAY: begin
          t.day = bcd_up(t.day);
          lim = month_len(t.month, t.year);
          if (t.month == MonthFeb) begin
            if (t.day > lim) t.day = DayFirst;
          end else if (lim != 8'h00 && t.day == lim + 8'd1) begin
            t.day = DayFirst;
          end
        end
        FIELD_WEEKDAY: begin
          t.weekday = t.weekday + 8'd1;
          if (t.weekday > WdayMax) t.weekday = 8'h01;
        end
        FIELD_HOUR: begin
          t.hour = bcd_up(t.hour);
          if (t.hour == HourWrap) t.hour = 8'h00;
        end
        FIELD_MIN: begin
          t.min = bcd_up(t.min);
          if (t.min == SixtyWrap) t.min = 8'h00;
        end
        FIELD_SEC: begin
          t.sec = bcd_up(t.sec);
          if (t.sec == SixtyWrap) t.sec = 8'h00;
        end
        FIELD_NONE: begin
          t = time_i;
        end
      endcase
    end else if (req_i == REQ_DEC) begin
      unique case (field_i)
        FIELD_YEAR: begin
          t.year = (t.year == 8'h00) ? YearMax : bcd_down(t.year);
          lim = month_len(MonthFeb, t.year);
          if (t.month == MonthFeb && t.day > lim) t.day = lim;
        end
        FIELD_MONTH: begin
          if (t.month == MonthJan) t.month = MonthDec;
          else if (t.month[3:0] == 4'h0) t.month = MonthSep;
          else t.month = t.month - 8'd1;
          lim = month_len(t.month, t.year);
          if (lim != 8'h00 && t.day > lim) t.day = lim;
        end
        FIELD_DAY: begin
          lim = month_len(t.month, t.year);
          if (lim != 8'h00 && t.day == DayFirst) t.day = lim;
          else t.day = bcd_down(t.day);
        end
        FIELD_WEEKDAY: begin
          t.weekday = t.weekday - 8'd1;
          if (t.weekday == 8'h00) t.weekday = WdayMax;
        end
        FIELD_HOUR: t.hour = (t.hour == 8'h00) ? HourMax : bcd_down(t.hour);
        FIELD_MIN:  t.min  = (t.min == 8'h00) ? SixtyMax : bcd_down(t.min);
        FIELD_SEC:  t.sec  = (t.sec == 8'h00) ? SixtyMax : bcd_down(t.sec);
        FIELD_NONE: begin
          t = time_i;
        end
      endcase
    end
    time_o = t;
  end

endmodule

`default_nettype wire

### src/bcd_calendar_time_editor.sv
// Top level of the BCD calendar time editor: input stage, edit logic, result stage
//
//   channel  direction  tdata                            tuser
//   s_axis   in         year..sec bytes (sec lowest)     req_type
//   m_axis   out        year..sec bytes (sec lowest)     edit_field, write_back
//
// One transaction per cycle sustained while m_axis_tready_i stays high; a result moves from
// the input register to the result register once the result register has room, with the whole edit done
// in one pass of the bcte_edit logic.
// Reset clears both stage valid flags and the field position (not editing).
// A stalled output holds its data; the input register takes a transaction while it is
// empty, or while the result register is empty or drained in the same cycle, so two
// transactions wait in the block before s_axis_tready_o drops.
`default_nettype none

module bcd_calendar_time_editor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // sec_in, min_in, hour_in, day_in, month_in, weekday_in, year_in
  input  wire logic [55:0] s_axis_tdata_i,
  // req_type
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // sec_out, min_out, hour_out, day_out, month_out, weekday_out, year_out
  output logic [55:0]      m_axis_tdata_o,
  // edit_field, write_back
  output logic [3:0]       m_axis_tuser_o
);
  import bcte_pkg::*;

  logic   in_valid_q;
  req_e   in_req_q;
  time_t  in_time_q;
  logic   out_valid_q;
  time_t  out_time_q;
  field_e field_select_q;
  field_e field_select_d;
  time_t  edit_time;
  logic   out_load;
  logic   in_load;

  // Flow control: each stage advances when the one after it has room
  assign out_load        = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || out_load;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      field_select_q <= FIELD_NONE;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (out_load) begin
        out_valid_q    <= 1'b1;
        field_select_q <= field_select_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_req_q  <= req_e'(s_axis_tuser_i);
      in_time_q <= time_t'(s_axis_tdata_i);
    end
    if (out_load) out_time_q <= edit_time;
  end

  // Edit logic
  bcte_edit u_edit (
    .req_i   (in_req_q),
    .field_i (field_select_q),
    .time_i  (in_time_q),
    .field_o (field_select_d),
    .time_o  (edit_time)
  );

  // Field position travels with the result it belongs to
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_time_q;
  assign m_axis_tuser_o  = {(field_select_q != FIELD_NONE), field_select_q};

  `include "bcd_calendar_time_editor_macros.svh"

  `BCTE_ASSERT_NEXT(a_exit_clears, out_load && in_req_q == REQ_EXIT, field_select_q == FIELD_NONE)
  `BCTE_ASSERT_NEXT(a_step_keeps_field, out_load && (in_req_q == REQ_INC || in_req_q == REQ_DEC), $stable(field_select_q))
  `BCTE_ASSERT_NEXT(a_stall_holds_input, in_valid_q && out_valid_q && !m_axis_tready_i, in_valid_q && $stable(in_time_q))
  `BCTE_ASSERT_IMPL(a_select_nonzero, out_load && in_req_q == REQ_SELECT, field_select_d != FIELD_NONE)

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the BCD calendar time editor: stream driver, sink and scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcte_pkg::*;

  localparam int unsigned RandomItems = 1050;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned TailCycles  = 10;

  // One expected transaction on the result channel
  typedef struct {
    time_t      clock;
    logic [2:0] field;
    logic       wr;
  } edit_result_t;

  // Tracks the field under edit and queues the edited clock bytes
  class calendar_scoreboard;
    logic [2:0]   sel;
    edit_result_t expected_q[$];
    int unsigned  errors;

    function new();
      sel    = FIELD_NONE;
      errors = 0;
    endfunction

    // Years run 2000..2165 for any nibble pair
    function logic is_leap(logic [7:0] y);
      int unsigned yr;
      yr = 2000 + 10 * y[7:4] + y[3:0];
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // BCD last day of the month, zero when the byte is not a month
    function logic [7:0] days_in_month(logic [7:0] m, logic [7:0] y);
      case (m)
        MonthFeb: return is_leap(y) ? 8'h29 : 8'h28;
        8'h01, 8'h03, 8'h05, 8'h07, 8'h08, 8'h10, 8'h12: return 8'h31;
        8'h04, 8'h06, 8'h09, 8'h11: return 8'h30;
        default: return 8'h00;
      endcase
    endfunction

    function logic [7:0] bcd_inc(logic [7:0] v);
      logic [7:0] s;
      s = v + 8'd1;
      if (s[3:0] == 4'ha) s = (s + 8'h10) & 8'hf0;
      return s;
    endfunction

    function logic [7:0] bcd_dec(logic [7:0] v);
      if (v[3:0] == 4'h0) return (v - 8'h10) | 8'h09;
      return v - 8'd1;
    endfunction

    // Only February pulls the day back after a year change
    function time_t clamp_feb(time_t t);
      logic [7:0] lim;
      if (t.month == MonthFeb) begin
        lim = days_in_month(MonthFeb, t.year);
        if (t.day > lim) t.day = lim;
      end
      return t;
    endfunction

    function time_t clamp_month(time_t t);
      logic [7:0] lim;
      lim = days_in_month(t.month, t.year);
      if (lim != 8'h00 && t.day > lim) t.day = lim;
      return t;
    endfunction

    function time_t step_up_field(time_t t);
      logic [7:0] lim;
      case (sel)
        FIELD_YEAR: begin
          t.year = bcd_inc(t.year);
          if (t.year == YearWrap) t.year = 8'h00;
          t = clamp_feb(t);
        end
        FIELD_MONTH: begin
          t.month = bcd_inc(t.month);
          if (t.month == MonthWrap) t.month = MonthJan;
          t = clamp_month(t);
        end
        FIELD_DAY: begin
          t.day = bcd_inc(t.day);
          lim   = days_in_month(t.month, t.year);
          // February wraps on any overshoot, other months only one past the end
          if (t.month == MonthFeb) begin
            if (t.day > lim) t.day = DayFirst;
          end else if (lim != 8'h00 && t.day == lim + 8'd1) begin
            t.day = DayFirst;
          end
        end
        FIELD_WEEKDAY: begin
          t.weekday = t.weekday + 8'd1;
          if (t.weekday > WdayMax) t.weekday = 8'h01;
        end
        FIELD_HOUR: begin
          t.hour = bcd_inc(t.hour);
          if (t.hour == HourWrap) t.hour = 8'h00;
        end
        FIELD_MIN: begin
          t.min = bcd_inc(t.min);
          if (t.min == SixtyWrap) t.min = 8'h00;
        end
        FIELD_SEC: begin
          t.sec = bcd_inc(t.sec);
          if (t.sec == SixtyWrap) t.sec = 8'h00;
        end
        default: ;
      endcase
      return t;
    endfunction

    function time_t step_down_field(time_t t);
      logic [7:0] lim;
      case (sel)
        FIELD_YEAR: begin
          t.year = (t.year == 8'h00) ? YearMax : bcd_dec(t.year);
          t = clamp_feb(t);
        end
        FIELD_MONTH: begin
          if (t.month == MonthJan) t.month = MonthDec;
          else if (t.month[3:0] == 4'h0) t.month = MonthSep;
          else t.month = t.month - 8'd1;
          t = clamp_month(t);
        end
        FIELD_DAY: begin
          lim = days_in_month(t.month, t.year);
          if (lim != 8'h00 && t.day == DayFirst) t.day = lim;
          else t.day = bcd_dec(t.day);
        end
        FIELD_WEEKDAY: begin
          t.weekday = t.weekday - 8'd1;
          if (t.weekday == 8'h00) t.weekday = WdayMax;
        end
        FIELD_HOUR: t.hour = (t.hour == 8'h00) ? HourMax : bcd_dec(t.hour);
        FIELD_MIN:  t.min  = (t.min == 8'h00) ? SixtyMax : bcd_dec(t.min);
        FIELD_SEC:  t.sec  = (t.sec == 8'h00) ? SixtyMax : bcd_dec(t.sec);
        default: ;
      endcase
      return t;
    endfunction

    // Called for every accepted key event
    function void note_input(req_e req, time_t t_in);
      edit_result_t r;
      r.clock = t_in;
      case (req)
        REQ_SELECT: sel = (sel == 3'(FIELD_SEC)) ? 3'(FIELD_YEAR) : 3'(sel + 3'd1);
        REQ_INC:    r.clock = step_up_field(r.clock);
        REQ_DEC:    r.clock = step_down_field(r.clock);
        default:    sel = FIELD_NONE;
      endcase
      r.field = sel;
      r.wr    = (sel != 3'(FIELD_NONE));
      expected_q.push_back(r);
    endfunction

    function void compare(string what, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s wrong: expected %h, actual %h", $time, what, exp_v, act_v);
      end
    endfunction

    // Called for every accepted result
    function void check_result(time_t got, logic [2:0] fld, logic wr);
      edit_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected nothing, actual %h field %0d",
                 $time, got, fld);
        return;
      end
      e = expected_q.pop_front();
      compare("sec", e.clock.sec, got.sec);
      compare("min", e.clock.min, got.min);
      compare("hour", e.clock.hour, got.hour);
      compare("day", e.clock.day, got.day);
      compare("month", e.clock.month, got.month);
      compare("weekday", e.clock.weekday, got.weekday);
      compare("year", e.clock.year, got.year);
      compare("edit_field", 8'(e.field), 8'(fld));
      compare("write_back", 8'(e.wr), 8'(wr));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void report_leftover();
      foreach (expected_q[i]) begin
        errors++;
        $display("%0t: missing result: expected %h field %0d, actual none",
                 $time, expected_q[i].clock, expected_q[i].field);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [3:0]  m_tuser;

  bit tx_gaps;
  bit rx_steady;
  bit hold_req;

  calendar_scoreboard sb = new();

  bcd_calendar_time_editor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Transactions are sampled at the edge, ahead of any update it causes
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) sb.note_input(req_e'(s_tuser), time_t'(s_tdata));
    if (rst_ni && m_tvalid && m_tready) sb.check_result(time_t'(m_tdata), m_tuser[2:0],
                                                         m_tuser[3]);
  end

  function automatic time_t mk(logic [7:0] y, logic [7:0] mo, logic [7:0] d,
                               logic [7:0] wd, logic [7:0] h, logic [7:0] mi,
                               logic [7:0] s);
    return time_t'({y, wd, mo, d, h, mi, s});
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned n);
    return 8'(((n / 10) << 4) | (n % 10));
  endfunction

  // Legal BCD value, leaning toward the ends of the range
  function automatic logic [7:0] edge_bcd(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(3);
    if (r == 0) return to_bcd(lo);
    if (r == 1) return to_bcd(hi);
    return to_bcd($urandom_range(hi, lo));
  endfunction

  // Well-formed date and time, with February and month ends favored
  function automatic time_t random_date();
    logic [7:0] y;
    logic [7:0] mo;
    logic [7:0] d;
    y  = edge_bcd(0, 99);
    mo = ($urandom_range(3) == 0) ? MonthFeb : edge_bcd(1, 12);
    d  = ($urandom_range(2) == 0) ? to_bcd($urandom_range(31, 28)) : edge_bcd(1, 31);
    return mk(y, mo, d, edge_bcd(1, 7), edge_bcd(0, 23), edge_bcd(0, 59), edge_bcd(0, 59));
  endfunction

  // Offer one key event and hold it until the block takes it
  task automatic send_item(input req_e req, input time_t t);
    if (tx_gaps) begin
      while ($urandom_range(99) < 21) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= t;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Result side: random stalls, one long hold-off, one stall-free stretch
  initial begin : sink
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (rx_steady) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin : stimulus
    req_e        req;
    time_t       t;
    int unsigned r;
    int unsigned k;
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = REQ_SELECT;
    tx_gaps   = 1'b1;
    rx_steady = 1'b0;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Not editing: bytes pass through
    send_item(REQ_INC, mk(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_item(REQ_DEC, mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // Year: century wrap both ways, leap Feb 29 kept then clamped, borrow
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h99, 8'h02, 8'h29, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h00, 8'h02, 8'h29, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h10, 8'h02, 8'h28, 8'h03, 8'h12, 8'h30, 8'h45));
    // Month: wraps and day limited to the new month
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h24, 8'h12, 8'h31, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h01, 8'h01, 8'h31, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h24, 8'h01, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h24, 8'h10, 8'h31, 8'h03, 8'h12, 8'h30, 8'h45));
    // Day: month-end wraps, leap February, invalid month byte
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h01, 8'h02, 8'h28, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h24, 8'h02, 8'h29, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h24, 8'h01, 8'h31, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h00, 8'h02, 8'h01, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h24, 8'h13, 8'h01, 8'h03, 8'h12, 8'h30, 8'h45));
    // Weekday wrap and the zero byte on decrement
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h24, 8'h06, 8'h15, 8'h07, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h24, 8'h06, 8'h15, 8'h00, 8'h12, 8'h30, 8'h45));
    // Hour, minute, second wraps
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h23, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h00, 8'h30, 8'h45));
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_INC, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h59, 8'h45));
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_DEC, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h00));
    // Select past the last field wraps to year, then leave editing
    send_item(REQ_SELECT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    send_item(REQ_EXIT, mk(8'h24, 8'h06, 8'h15, 8'h03, 8'h12, 8'h30, 8'h45));
    drain();

    // Random key events over mostly legal dates, some noise bytes
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == 150) hold_req = 1'b1;
      if (i == 400) begin
        tx_gaps   = 1'b0;
        rx_steady = 1'b1;
      end
      if (i == 600) begin
        tx_gaps   = 1'b1;
        rx_steady = 1'b0;
      end
      if (i == 800) drain();
      r = $urandom_range(99);
      if (r < 30) req = REQ_SELECT;
      else if (r < 62) req = REQ_INC;
      else if (r < 94) req = REQ_DEC;
      else req = REQ_EXIT;
      r = $urandom_range(99);
      if (r < 12) begin
        t = time_t'(56'({$urandom(), $urandom()}));
      end else begin
        t = random_date();
        if (r < 20) begin
          k = $urandom_range(6);
          t[8*k +: 8] = 8'($urandom());
        end
      end
      send_item(req, t);
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
